FILE: rtl/row_scatter_add_accumulator_unit_macros.svh
// assertion macros used by the checker file
`ifndef ROW_SCATTER_ADD_ACCUMULATOR_UNIT_MACROS_SVH
`define ROW_SCATTER_ADD_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication, off while reset is held
`define RSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scatter-add check failed");

// next-cycle implication, off while reset is held
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scatter-add check failed");

`endif

FILE: rtl/rsa_pkg.sv
// shared constants, types and the half to single conversion
package rsa_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  localparam logic [1:0] CFG_ROW_COUNT      = 2'd0;
  localparam logic [1:0] CFG_COLUMN_COUNT   = 2'd1;
  localparam logic [1:0] CFG_SOURCE_IS_HALF = 2'd2;

  localparam logic REQ_ACCUM = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [8:0] ROW_COUNT_RST    = 9'd256;
  localparam logic [6:0] COLUMN_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [8:0] row_count;
    logic [6:0] column_count;
    logic       source_is_half;
  } cfg_regs_t;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_OP    = 7'b0001000,
    ST_SUM   = 7'b0010000,
    ST_NORM  = 7'b0100000,
    ST_ROUND = 7'b1000000
  } back_state_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] e;
    logic [9:0] f;
    logic [3:0] sh;
    logic [9:0] fn;
    logic [7:0] ex;
    s  = h[15];
    e  = h[14:10];
    f  = h[9:0];
    sh = 4'd0;
    // highest set bit decides the normalizing shift of a subnormal
    for (int i = 0; i < 10; i++) begin
      if (f[i]) sh = 4'(10 - i);
    end
    fn = f << sh;
    ex = 8'd113 - {4'd0, sh};
    if (e == 5'd31) begin
      half_to_single = {s, 8'hFF, f, 13'd0};
    end else if (e == 5'd0) begin
      if (f == 10'd0) half_to_single = {s, 31'd0};
      else            half_to_single = {s, ex, fn, 13'd0};
    end else begin
      half_to_single = {s, {3'd0, e} + 8'd112, f, 13'd0};
    end
  endfunction

endpackage

FILE: rtl/rsa_queue.sv
// small first-in first-out queue of fixed-width items
module rsa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= din;
  end

endmodule

FILE: rtl/rsa_front.sv
// front end: configuration registers, range check, address and value widening
module rsa_front import rsa_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64,
  parameter int ADDR_W   = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_req_type,
  input  logic signed [31:0] in_target_row,
  input  logic [5:0]        in_column,
  input  logic [31:0]       in_grad_value,
  output logic              cmd_req,
  output logic              cmd_bad,
  output logic [31:0]       cmd_value,
  output logic [ADDR_W-1:0] cmd_addr
);
  localparam logic [31:0] ROWS_LIM = 32'(MAX_ROWS);
  localparam logic [31:0] COLS_LIM = 32'(MAX_COLS);

  cfg_regs_t   cfg_r, cfg_nxt;
  logic [31:0] row_bits, rlim, clim, col_w, addr_w32;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:      cfg_nxt.row_count      = cfg_data;
        CFG_COLUMN_COUNT:   cfg_nxt.column_count   = cfg_data[6:0];
        CFG_SOURCE_IS_HALF: cfg_nxt.source_is_half = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_count: ROW_COUNT_RST, column_count: COLUMN_COUNT_RST,
                 source_is_half: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign row_bits = in_target_row;
  assign col_w    = {26'd0, in_column};
  assign rlim = ({23'd0, cfg_r.row_count} < ROWS_LIM) ? {23'd0, cfg_r.row_count} : ROWS_LIM;
  assign clim = ({25'd0, cfg_r.column_count} < COLS_LIM) ?
                {25'd0, cfg_r.column_count} : COLS_LIM;

  // negative rows fail on the sign bit alone
  assign cmd_bad  = row_bits[31] || (row_bits >= rlim) || (col_w >= clim);
  assign addr_w32 = row_bits * COLS_LIM + col_w;
  assign cmd_addr = addr_w32[ADDR_W-1:0];
  assign cmd_req  = in_req_type;
  assign cmd_value = cfg_r.source_is_half ? half_to_single(in_grad_value[15:0])
                                          : in_grad_value;

endmodule

FILE: rtl/rsa_back.sv
// back end: table memory, clearing pass, read-and-clear and multi-cycle single precision add
module rsa_back import rsa_pkg::*; #(
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  logic              cmd_req,
  input  logic              cmd_bad,
  input  logic [31:0]       cmd_value,
  input  logic [ADDR_W-1:0] cmd_addr,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output logic              res_status,
  output logic [31:0]       res_sum,
  output logic              clearing
);
  logic [31:0] mem [DEPTH];

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt, addr_r, addr_nxt;
  logic              req_r, req_nxt, s_r, s_nxt, sub_r, sub_nxt;
  logic [31:0]       b_r, b_nxt, rdata_r;
  logic [26:0]       ma_r, ma_nxt, mb_r, mb_nxt, m_r, m_nxt;
  logic [8:0]        e_r, e_nxt;
  logic [4:0]        sh_r, sh_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [31:0]       mem_wd;

  // operand unpack and alignment
  logic [7:0]  ea, eb, xea, xeb, big_e, lit_e, d;
  logic [22:0] fa, fb;
  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swap, big_s;
  logic [26:0] xma, xmb, big_m, lit_m, lit_sh;
  // sum, normalize, round
  logic [27:0] sum28;
  logic [26:0] diff, mn;
  logic [4:0]  lz;
  logic [8:0]  lim, en, ef;
  logic [23:0] mm, mf;
  logic [24:0] mr;
  logic [2:0]  g;
  logic        inc;
  logic [31:0] rnd_res;

  assign clearing = (state_r == ST_CLEAR);

  assign ea = rdata_r[30:23];
  assign eb = b_r[30:23];
  assign fa = rdata_r[22:0];
  assign fb = b_r[22:0];
  assign sa = rdata_r[31];
  assign sb = b_r[31];
  assign a_nan = (ea == 8'hFF) && (fa != 23'd0);
  assign b_nan = (eb == 8'hFF) && (fb != 23'd0);
  assign a_inf = (ea == 8'hFF) && (fa == 23'd0);
  assign b_inf = (eb == 8'hFF) && (fb == 23'd0);
  assign xma = {(ea != 8'd0), fa, 3'b000};
  assign xmb = {(eb != 8'd0), fb, 3'b000};
  assign xea = (ea == 8'd0) ? 8'd1 : ea;
  assign xeb = (eb == 8'd0) ? 8'd1 : eb;
  assign swap  = (xeb > xea) || ((xeb == xea) && (xmb > xma));
  assign big_e = swap ? xeb : xea;
  assign lit_e = swap ? xea : xeb;
  assign big_m = swap ? xmb : xma;
  assign lit_m = swap ? xma : xmb;
  assign big_s = swap ? sb : sa;
  assign d     = big_e - lit_e;
  // shifts past the width leave only the sticky bit
  assign lit_sh = (lit_m >> d) | {26'd0, |(lit_m & ~(27'h7FF_FFFF << d))};

  assign sum28 = {1'b0, ma_r} + {1'b0, mb_r};
  assign diff  = ma_r - mb_r;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (m_r[i]) lz = 5'(26 - i);
    end
  end
  assign lim = e_r - 9'd1;

  assign mn  = m_r << sh_r;
  assign en  = e_r - {4'd0, sh_r};
  assign g   = mn[2:0];
  assign mm  = mn[26:3];
  assign inc = (g > 3'd4) || ((g == 3'd4) && mm[0]);
  assign mr  = {1'b0, mm} + {24'd0, inc};
  assign mf  = mr[24] ? mr[24:1] : mr[23:0];
  assign ef  = mr[24] ? en + 9'd1 : en;
  assign rnd_res = (ef >= 9'd255) ? {s_r, 8'hFF, 23'd0}
                                  : {s_r, (mf[23] ? ef[7:0] : 8'd0), mf[22:0]};

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    addr_nxt   = addr_r;
    req_nxt    = req_r;
    b_nxt      = b_r;
    s_nxt      = s_r;
    sub_nxt    = sub_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    m_nxt      = m_r;
    e_nxt      = e_r;
    sh_nxt     = sh_r;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_status = 1'b0;
    res_sum    = 32'd0;
    mem_we     = 1'b0;
    mem_wa     = addr_r;
    mem_wd     = 32'd0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          if (cmd_bad) begin
            res_push   = 1'b1;
            res_status = 1'b1;
          end else begin
            addr_nxt  = cmd_addr;
            req_nxt   = cmd_req;
            b_nxt     = cmd_value;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = ST_OP;
      ST_OP: begin
        if (req_r == REQ_READ) begin
          mem_we    = 1'b1;
          res_push  = 1'b1;
          res_sum   = rdata_r;
          state_nxt = ST_IDLE;
        end else if (a_nan || b_nan || a_inf || b_inf) begin
          mem_we = 1'b1;
          if (a_nan || b_nan)      mem_wd = QNAN_BITS;
          else if (a_inf && b_inf) mem_wd = (sa == sb) ? rdata_r : QNAN_BITS;
          else if (a_inf)          mem_wd = rdata_r;
          else                     mem_wd = b_r;
          res_push  = 1'b1;
          res_sum   = mem_wd;
          state_nxt = ST_IDLE;
        end else begin
          ma_nxt    = big_m;
          mb_nxt    = lit_sh;
          e_nxt     = {1'b0, big_e};
          s_nxt     = big_s;
          sub_nxt   = sa ^ sb;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!sub_r) begin
          if (sum28[27]) begin
            m_nxt = sum28[27:1] | {26'd0, sum28[0]};
            e_nxt = e_r + 9'd1;
          end else begin
            m_nxt = sum28[26:0];
          end
          state_nxt = ST_NORM;
        end else if (diff == 27'd0) begin
          // exact cancellation gives positive zero
          mem_we    = 1'b1;
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          m_nxt     = diff;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // stop the left shift at the smallest exponent
        sh_nxt    = ({4'd0, lz} < lim) ? lz : lim[4:0];
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        mem_we    = 1'b1;
        mem_wd    = rnd_res;
        res_push  = 1'b1;
        res_sum   = rnd_res;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    req_r  <= req_nxt;
    b_r    <= b_nxt;
    s_r    <= s_nxt;
    sub_r  <= sub_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    sh_r   <= sh_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[addr_r];
  end

endmodule

FILE: rtl/row_scatter_add_accumulator_unit.sv
// top level of the scatter-add accumulator
//
//  channel  direction  handshake        payload
//  in_      input      in_push/in_full  req_type, target_row, column, grad_value
//  out_     output     out_pop/out_empty status, sum_value
//  cfg_     input      cfg_we           cfg_index, cfg_data
//
// in the back end an accumulate item passes the states read, align, add, normalize
// and round (exact cancellation ends at add); a NaN or infinity operand or a read
// item ends after align, an out-of-range item in idle; one item at a time, one table port.
// after reset a clearing pass writes zero to all MAX_ROWS*MAX_COLS entries, one a
// cycle; in_full stays high until it ends.
// a two-item queue sits on each side of the back end, so stalls on out_pop do not
// block input until both queues fill.
module row_scatter_add_accumulator_unit import rsa_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_req_type,
  input  logic signed [31:0] in_target_row,
  input  logic [5:0]         in_column,
  input  logic [31:0]        in_grad_value,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_status,
  output logic [31:0]        out_sum_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMD_W  = ADDR_W + 34;

  logic              f_req, f_bad, b_req, b_bad, cmd_full, cmd_empty, cmd_pop;
  logic [31:0]       f_value, b_value, res_sum;
  logic [ADDR_W-1:0] f_addr, b_addr;
  logic [CMD_W-1:0]  cmd_head;
  logic              res_full, res_push, res_status, clearing;
  logic [32:0]       res_head;

  assign in_full = cmd_full || clearing;

  rsa_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .ADDR_W(ADDR_W)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_req_type, .in_target_row, .in_column, .in_grad_value,
    .cmd_req(f_req), .cmd_bad(f_bad), .cmd_value(f_value), .cmd_addr(f_addr)
  );

  rsa_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk, .rst_n,
    .push(in_push && !in_full),
    .din({f_req, f_bad, f_value, f_addr}),
    .pop(cmd_pop), .dout(cmd_head), .full(cmd_full), .empty(cmd_empty)
  );

  assign {b_req, b_bad, b_value, b_addr} = cmd_head;

  rsa_back #(.ADDR_W(ADDR_W), .DEPTH(DEPTH)) u_back (
    .clk, .rst_n, .cmd_empty, .cmd_req(b_req), .cmd_bad(b_bad),
    .cmd_value(b_value), .cmd_addr(b_addr), .cmd_pop,
    .res_full, .res_push, .res_status, .res_sum, .clearing
  );

  rsa_queue #(.WIDTH(33), .DEPTH(2)) u_res_q (
    .clk, .rst_n, .push(res_push), .din({res_status, res_sum}),
    .pop(out_pop), .dout(res_head), .full(res_full), .empty(out_empty)
  );

  assign out_status    = res_head[32];
  assign out_sum_value = res_head[31:0];

endmodule

FILE: rtl/rsa_checker.sv
// port-level checks on the scatter-add accumulator, bound to the top level
`include "row_scatter_add_accumulator_unit_macros.svh"

module rsa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic               out_status,
  input logic [31:0]        out_sum_value
);
  // a waiting result stays until taken
  `RSA_ASSERT_NEXT(a_out_held, !out_empty && !out_pop, !out_empty)
  // a rejected item carries a zero sum
  `RSA_ASSERT_NOW(a_reject_zero, !out_empty && out_status, out_sum_value == 32'd0)
  // a waiting result never shows unknown bits
  `RSA_ASSERT_NOW(a_out_known, !out_empty, !$isunknown({out_status, out_sum_value}))
  // handshake flags are always driven out of reset
  `RSA_ASSERT_NOW(a_flags_known, 1'b1, !$isunknown({in_full, out_empty}))
endmodule

bind row_scatter_add_accumulator_unit rsa_checker u_rsa_checker (.*);

FILE: dv/tb_row_scatter_add_accumulator_unit.sv
// testbench for the scatter-add accumulator: random and directed items checked against a predictor
module tb_row_scatter_add_accumulator_unit;
  import rsa_pkg::*;

  localparam int ROWS = 256;
  localparam int COLS = 64;

  // predictor of the table and the result queue
  class sum_scoreboard;
    logic [31:0] table_q [ROWS*COLS];
    logic [8:0]  rows_in_use;
    logic [6:0]  cols_in_use;
    logic        half_src;
    logic        exp_status [$];
    logic [31:0] exp_sum [$];
    int          errors;

    function void init();
      foreach (table_q[i]) table_q[i] = 32'd0;
      rows_in_use = ROW_COUNT_RST;
      cols_in_use = COLUMN_COUNT_RST;
      half_src = 1'b0;
      errors = 0;
    endfunction

    function logic [31:0] widen_half(logic [15:0] h);
      logic [9:0] f;
      int ex;
      f = h[9:0];
      ex = 1;
      if (h[14:10] == 5'd31) return {h[15], 8'hFF, f, 13'd0};
      if (h[14:10] != 5'd0) return {h[15], 8'(h[14:10] + 112), f, 13'd0};
      if (f == 10'd0) return {h[15], 31'd0};
      while (!f[9]) begin
        f = f << 1;
        ex--;
      end
      // leading one moves out of the ten-bit field
      f = f << 1;
      ex--;
      return {h[15], 8'(ex + 112), f, 13'd0};
    endfunction

    function logic [31:0] add_single(logic [31:0] a, logic [31:0] b);
      logic [31:0] ea, eb, ma, mb, m, e, d, g, t;
      logic sa, sb, ts;
      ea = a[30:23]; eb = b[30:23];
      sa = a[31]; sb = b[31];
      if ((ea == 255 && a[22:0] != 0) || (eb == 255 && b[22:0] != 0)) return QNAN_BITS;
      if (ea == 255 && eb == 255) return (sa == sb) ? a : QNAN_BITS;
      if (ea == 255) return a;
      if (eb == 255) return b;
      ma = (ea == 0) ? {9'd0, a[22:0]} : {9'd1, a[22:0]};
      mb = (eb == 0) ? {9'd0, b[22:0]} : {9'd1, b[22:0]};
      if (ea == 0) ea = 1;
      if (eb == 0) eb = 1;
      ma = ma << 3; mb = mb << 3;
      if (eb > ea || (eb == ea && mb > ma)) begin
        t = ea; ea = eb; eb = t;
        t = ma; ma = mb; mb = t;
        ts = sa; sa = sb; sb = ts;
      end
      d = ea - eb;
      if (d > 30) mb = (mb != 0) ? 1 : 0;
      else if (d > 0) mb = (mb >> d) | (((mb & ((32'd1 << d) - 1)) != 0) ? 1 : 0);
      e = ea;
      if (sa == sb) begin
        m = ma + mb;
        if (m[27]) begin
          m = (m >> 1) | (m & 1);
          e++;
        end
      end else begin
        m = ma - mb;
        if (m == 0) return 32'd0;
        while (m < (32'd1 << 26) && e > 1) begin
          m = m << 1;
          e--;
        end
      end
      g = m & 7;
      m = m >> 3;
      if (g > 4 || (g == 4 && m[0])) m++;
      if (m == (32'd1 << 24)) begin
        m = m >> 1;
        e++;
      end
      if (e >= 255) return {sa, 31'h7F80_0000};
      return {sa, (m[23] ? e[7:0] : 8'd0), m[22:0]};
    endfunction

    function void note_item(logic req, logic [31:0] row, logic [5:0] col, logic [31:0] grad);
      int idx;
      int rlim;
      int clim;
      rlim = (rows_in_use < ROWS) ? rows_in_use : ROWS;
      clim = (cols_in_use < COLS) ? cols_in_use : COLS;
      if (row[31] || row >= rlim || col >= clim) begin
        exp_status.push_back(1'b1);
        exp_sum.push_back(32'd0);
        return;
      end
      idx = row * COLS + col;
      exp_status.push_back(1'b0);
      if (req == REQ_ACCUM) begin
        table_q[idx] = add_single(table_q[idx], half_src ? widen_half(grad[15:0]) : grad);
        exp_sum.push_back(table_q[idx]);
      end else begin
        exp_sum.push_back(table_q[idx]);
        table_q[idx] = 32'd0;
      end
    endfunction

    function void check_result(logic st, logic [31:0] sum);
      logic es;
      logic [31:0] ev;
      if (exp_sum.size() == 0) begin
        $display("%0t: unexpected result status %0d sum %h", $time, st, sum);
        errors++;
        return;
      end
      es = exp_status.pop_front();
      ev = exp_sum.pop_front();
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (sum !== ev) begin
        $display("%0t: sum_value expected %h actual %h", $time, ev, sum);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  logic in_req_type;
  logic signed [31:0] in_target_row;
  logic [5:0] in_column;
  logic [31:0] in_grad_value;
  logic out_empty;
  logic out_pop;
  logic out_status;
  logic [31:0] out_sum_value;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  sum_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  bit driving_done;

  row_scatter_add_accumulator_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_row_scatter_add_accumulator_unit: FAIL");
    $finish;
  end

  // result side: random pops, plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) sb.check_result(out_status, out_sum_value);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // push stays high between back-to-back items; idle cycles and drain lower it
  task automatic push_item(logic req, logic [31:0] row, logic [5:0] col, logic [31:0] grad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_req_type <= req;
    in_target_row <= row;
    in_column <= col;
    in_grad_value <= grad;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(req, row, col, grad);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROW_COUNT: sb.rows_in_use = val;
      CFG_COLUMN_COUNT: sb.cols_in_use = val[6:0];
      CFG_SOURCE_IS_HALF: sb.half_src = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.exp_sum.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_grad(bit half);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'd127 + 8'($urandom_range(6)) - 8'd3;
      default: ;
    endcase
    if (half && $urandom_range(3) == 0) v[14:10] = ($urandom_range(1)) ? 5'd31 : 5'd0;
    return v;
  endfunction

  task automatic random_phase(int n, int rlim, int clim, bit half);
    int r;
    int c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(rlim > 4 ? 3 : rlim - 1);
      if ($urandom_range(3) == 0) r = $urandom_range(rlim - 1);
      c = $urandom_range(clim - 1);
      if ($urandom_range(9) == 0) begin
        // out of range row, or a column drawn from the full field
        if ($urandom_range(1)) r = $urandom_range(1) ? int'($urandom | 32'h8000_0000) : rlim + $urandom_range(300);
        else c = $urandom_range(63);
      end
      push_item(($urandom_range(4) == 0) ? REQ_READ : REQ_ACCUM, r, c[5:0], rand_grad(half));
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_req_type = REQ_ACCUM;
    in_target_row = '0;
    in_column = '0;
    in_grad_value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, cancellation, overflow, nan, zeros
    push_item(REQ_ACCUM, 0, 6'd0, 32'h3F80_0000);
    push_item(REQ_ACCUM, 0, 6'd0, 32'hBF80_0000);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h8000_0000);
    push_item(REQ_READ, 0, 6'd0, 32'hFFFF_FFFF);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h8000_0000);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h8000_0000);
    push_item(REQ_ACCUM, 255, 6'd63, 32'h7F7F_FFFF);
    push_item(REQ_ACCUM, 255, 6'd63, 32'h7F7F_FFFF);
    push_item(REQ_ACCUM, 255, 6'd63, 32'hFF80_0000);
    push_item(REQ_READ, 255, 6'd63, 32'h0);
    push_item(REQ_ACCUM, 1, 6'd1, 32'h7FA0_0001);
    push_item(REQ_ACCUM, 2, 6'd2, 32'h0000_0001);
    push_item(REQ_ACCUM, 2, 6'd2, 32'h807F_FFFF);
    push_item(REQ_ACCUM, 32'h8000_0000, 6'd0, 32'h3F80_0000);
    push_item(REQ_ACCUM, 32'h7FFF_FFFF, 6'd0, 32'h3F80_0000);
    push_item(REQ_READ, 256, 6'd5, 32'h0);
    push_item(REQ_READ, 1, 6'd1, 32'h0);
    drain();

    write_reg(CFG_SOURCE_IS_HALF, 9'd1);
    write_reg(CFG_ROW_COUNT, 9'd1);
    write_reg(CFG_COLUMN_COUNT, 9'd1);
    push_item(REQ_ACCUM, 0, 6'd0, 32'hFFFF_3C00);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h0000_0001);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h0000_83FF);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h0000_7C00);
    push_item(REQ_ACCUM, 0, 6'd0, 32'h0000_FE01);
    push_item(REQ_ACCUM, 0, 6'd1, 32'h0000_3C00);
    push_item(REQ_ACCUM, 1, 6'd0, 32'h0000_3C00);
    push_item(REQ_READ, 0, 6'd0, 32'h0);
    drain();
    write_reg(CFG_ROW_COUNT, 9'd0);
    push_item(REQ_READ, 0, 6'd0, 32'h0);
    drain();

    // random phases through several register settings and idle profiles
    send_idle_pct = 33; recv_idle_pct = 65;
    write_reg(CFG_ROW_COUNT, 9'd256);
    write_reg(CFG_COLUMN_COUNT, 9'd64);
    write_reg(CFG_SOURCE_IS_HALF, 9'd0);
    random_phase(150, 256, 64, 1'b0);
    drain();
    send_idle_pct = 65; recv_idle_pct = 33;
    write_reg(CFG_SOURCE_IS_HALF, 9'd1);
    write_reg(CFG_ROW_COUNT, 9'd3);
    write_reg(CFG_COLUMN_COUNT, 9'd2);
    random_phase(150, 3, 2, 1'b1);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_ROW_COUNT, 9'd200);
    write_reg(CFG_COLUMN_COUNT, 9'd40);
    hold_cycles = 300;
    random_phase(200, 200, 40, 1'b1);
    drain();
    write_reg(CFG_SOURCE_IS_HALF, 9'd0);
    write_reg(CFG_ROW_COUNT, 9'd256);
    write_reg(CFG_COLUMN_COUNT, 9'd64);
    random_phase(200, 256, 64, 1'b0);
    drain();

    if (sb.errors == 0 && sb.exp_sum.size() == 0) begin
      $display("tb_row_scatter_add_accumulator_unit: PASS");
    end else begin
      $display("tb_row_scatter_add_accumulator_unit: FAIL");
    end
    $finish;
  end

endmodule
